// ===== hw/rtl/ecsm_pkg.sv =====
`timescale 1ns / 1ps

package ecsm_pkg;

	localparam int COORD_W    = 32;
	localparam int SCALAR_W   = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_PHYS   = 20;
	localparam int PC_W       = 7;

	localparam logic [COORD_W-1:0] MODULUS_RESET = 32'd1000000007;
	localparam logic [COORD_W-1:0] CURVE_A_RESET = 32'd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'b1;

	// item commands
	localparam logic CMD_MUL = 1'b0;
	localparam logic CMD_ADD = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [COORD_W-1:0]  px;
		logic [COORD_W-1:0]  py;
		logic [COORD_W-1:0]  qx;
		logic [COORD_W-1:0]  qy;
		logic [SCALAR_W-1:0] scalar;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] rx;
		logic [COORD_W-1:0] ry;
	} result_t;

	// register file addresses; the V_ entries are resolved by the sequencer
	typedef enum logic [4:0] {
		R_PX, R_PY, R_QX, R_QY, R_AX, R_AY, R_A, R_ONE, R_NUM, R_DEN,
		R_LAM, R_XR, R_YR, R_T, R_Q, R_TQ, R_RA, R_RB, R_TA, R_TB,
		V_UX, V_UY, V_VX, V_VY, V_DX, V_DY, V_ROLD, V_RNEW, V_TOLD, V_TNEW
	} raddr_t;

	typedef enum logic [3:0] {
		OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LD0, OP_LD1,
		OP_LDP, OP_TST, OP_EQ, OP_OUT, OP_KLD, OP_KSH
	} dp_op_t;

	typedef enum logic [2:0] {
		MS_PX, MS_PY, MS_QX, MS_QY, MS_A
	} msel_t;

	typedef enum logic [2:0] {
		UK_OP, UK_BR, UK_CALL, UK_RET, UK_SWAP, UK_END
	} ukind_t;

	typedef enum logic [2:0] {
		C_ALWAYS, C_FLAG, C_NFLAG, C_KZERO, C_KLSB0, C_PSMALL, C_CMDADD
	} cond_t;

	typedef enum logic [1:0] {
		MODE_PQ, MODE_ACC, MODE_DBL
	} mode_t;

	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		ukind_t kind;
		dp_op_t op;
		raddr_t dst;
		raddr_t sa;
		raddr_t sb;
		msel_t  msel;
		cond_t  cond;
		mode_t  mode;
		pc_t    target;
	} uinstr_t;

	typedef struct packed {
		logic   valid;
		dp_op_t op;
		raddr_t dst;
		raddr_t sa;
		raddr_t sb;
		msel_t  msel;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic flag;
		logic k_zero;
		logic k_lsb;
		logic p_small;
		logic cmd_add;
	} dp_status_t;

	// program labels
	localparam pc_t L_LOOP = 7'd11;
	localparam pc_t L_ADD  = 7'd18;
	localparam pc_t L_OUT  = 7'd19;
	localparam pc_t L_PADD = 7'd21;
	localparam pc_t L_VCHK = 7'd26;
	localparam pc_t L_NZ   = 7'd31;
	localparam pc_t L_GEN  = 7'd41;
	localparam pc_t L_INV  = 7'd43;
	localparam pc_t L_EUC  = 7'd49;
	localparam pc_t L_EEND = 7'd56;
	localparam pc_t L_INF  = 7'd68;

	function automatic uinstr_t u_op(input dp_op_t op, input raddr_t d, input raddr_t a,
			input raddr_t b);
		uinstr_t u;
		u = '0;
		u.kind = UK_OP;
		u.op = op;
		u.dst = d;
		u.sa = a;
		u.sb = b;
		return u;
	endfunction

	function automatic uinstr_t u_mod(input raddr_t d, input msel_t m);
		uinstr_t u;
		u = '0;
		u.kind = UK_OP;
		u.op = OP_MOD;
		u.dst = d;
		u.msel = m;
		return u;
	endfunction

	function automatic uinstr_t u_br(input cond_t c, input pc_t t);
		uinstr_t u;
		u = '0;
		u.kind = UK_BR;
		u.cond = c;
		u.target = t;
		return u;
	endfunction

	function automatic uinstr_t u_call(input mode_t m, input pc_t t);
		uinstr_t u;
		u = '0;
		u.kind = UK_CALL;
		u.mode = m;
		u.target = t;
		return u;
	endfunction

	function automatic uinstr_t u_kind(input ukind_t k);
		uinstr_t u;
		u = '0;
		u.kind = k;
		return u;
	endfunction

	// sequencer program: double-and-add over a point-add subroutine
	function automatic uinstr_t ucode(input pc_t pc);
		uinstr_t u;
		unique case (pc)
			7'd0:  u = u_op(OP_LD0, R_AX, R_PX, R_PX);
			7'd1:  u = u_op(OP_LD0, R_AY, R_PX, R_PX);
			7'd2:  u = u_br(C_PSMALL, L_OUT);
			7'd3:  u = u_mod(R_A, MS_A);
			7'd4:  u = u_mod(R_PX, MS_PX);
			7'd5:  u = u_mod(R_PY, MS_PY);
			7'd6:  u = u_mod(R_QX, MS_QX);
			7'd7:  u = u_mod(R_QY, MS_QY);
			7'd8:  u = u_op(OP_LD1, R_ONE, R_PX, R_PX);
			7'd9:  u = u_br(C_CMDADD, L_ADD);
			7'd10: u = u_op(OP_KLD, R_PX, R_PX, R_PX);
			7'd11: u = u_br(C_KZERO, L_OUT);
			7'd12: u = u_br(C_KLSB0, 7'd14);
			7'd13: u = u_call(MODE_ACC, L_PADD);
			7'd14: u = u_op(OP_KSH, R_PX, R_PX, R_PX);
			7'd15: u = u_br(C_KZERO, L_OUT);
			7'd16: u = u_call(MODE_DBL, L_PADD);
			7'd17: u = u_br(C_ALWAYS, L_LOOP);
			7'd18: u = u_call(MODE_PQ, L_PADD);
			7'd19: u = u_op(OP_OUT, R_PX, R_AX, R_AY);
			7'd20: u = u_kind(UK_END);
			7'd21: u = u_op(OP_TST, R_PX, V_UX, V_UY);
			7'd22: u = u_br(C_NFLAG, L_VCHK);
			7'd23: u = u_op(OP_MOV, V_DX, V_VX, V_VX);
			7'd24: u = u_op(OP_MOV, V_DY, V_VY, V_VY);
			7'd25: u = u_kind(UK_RET);
			7'd26: u = u_op(OP_TST, R_PX, V_VX, V_VY);
			7'd27: u = u_br(C_NFLAG, L_NZ);
			7'd28: u = u_op(OP_MOV, V_DX, V_UX, V_UX);
			7'd29: u = u_op(OP_MOV, V_DY, V_UY, V_UY);
			7'd30: u = u_kind(UK_RET);
			7'd31: u = u_op(OP_EQ, R_PX, V_UX, V_VX);
			7'd32: u = u_br(C_NFLAG, L_GEN);
			7'd33: u = u_op(OP_EQ, R_PX, V_UY, V_VY);
			7'd34: u = u_br(C_NFLAG, L_GEN);
			7'd35: u = u_op(OP_MUL, R_T, V_UX, V_UX);
			7'd36: u = u_op(OP_ADD, R_NUM, R_T, R_T);
			7'd37: u = u_op(OP_ADD, R_NUM, R_NUM, R_T);
			7'd38: u = u_op(OP_ADD, R_NUM, R_NUM, R_A);
			7'd39: u = u_op(OP_ADD, R_DEN, V_UY, V_UY);
			7'd40: u = u_br(C_ALWAYS, L_INV);
			7'd41: u = u_op(OP_SUB, R_NUM, V_VY, V_UY);
			7'd42: u = u_op(OP_SUB, R_DEN, V_VX, V_UX);
			7'd43: u = u_op(OP_TST, R_PX, R_DEN, R_DEN);
			7'd44: u = u_br(C_FLAG, L_INF);
			7'd45: u = u_op(OP_LDP, V_ROLD, R_PX, R_PX);
			7'd46: u = u_op(OP_MOV, V_RNEW, R_DEN, R_DEN);
			7'd47: u = u_op(OP_LD0, V_TOLD, R_PX, R_PX);
			7'd48: u = u_op(OP_LD1, V_TNEW, R_PX, R_PX);
			7'd49: u = u_op(OP_TST, R_PX, V_RNEW, V_RNEW);
			7'd50: u = u_br(C_FLAG, L_EEND);
			7'd51: u = u_op(OP_DIV, R_Q, V_ROLD, V_RNEW);
			7'd52: u = u_op(OP_MUL, R_TQ, R_Q, V_TNEW);
			7'd53: u = u_op(OP_SUB, V_TOLD, V_TOLD, R_TQ);
			7'd54: u = u_kind(UK_SWAP);
			7'd55: u = u_br(C_ALWAYS, L_EUC);
			7'd56: u = u_op(OP_EQ, R_PX, V_ROLD, R_ONE);
			7'd57: u = u_br(C_NFLAG, L_INF);
			7'd58: u = u_op(OP_MUL, R_LAM, R_NUM, V_TOLD);
			7'd59: u = u_op(OP_MUL, R_T, R_LAM, R_LAM);
			7'd60: u = u_op(OP_SUB, R_T, R_T, V_UX);
			7'd61: u = u_op(OP_SUB, R_XR, R_T, V_VX);
			7'd62: u = u_op(OP_SUB, R_T, V_UX, R_XR);
			7'd63: u = u_op(OP_MUL, R_T, R_LAM, R_T);
			7'd64: u = u_op(OP_SUB, R_YR, R_T, V_UY);
			7'd65: u = u_op(OP_MOV, V_DX, R_XR, R_XR);
			7'd66: u = u_op(OP_MOV, V_DY, R_YR, R_YR);
			7'd67: u = u_kind(UK_RET);
			7'd68: u = u_op(OP_LD0, V_DX, R_PX, R_PX);
			7'd69: u = u_op(OP_LD0, V_DY, R_PX, R_PX);
			7'd70: u = u_kind(UK_RET);
			default: u = u_kind(UK_END);
		endcase
		return u;
	endfunction

endpackage

// ===== hw/rtl/ecsm_ctrl.sv =====
`timescale 1ns / 1ps

module ecsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output ecsm_pkg::dp_cmd_t     cmd,
	input  ecsm_pkg::dp_status_t  status
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_WAIT  = 3'b100
	} state_t;

	state_t               state_q;
	ecsm_pkg::pc_t        pc_q;
	ecsm_pkg::pc_t        ret_q;
	ecsm_pkg::mode_t      mode_q;
	logic                 swap_q;
	ecsm_pkg::dp_cmd_t    cmd_q;
	ecsm_pkg::uinstr_t    ui;
	logic                 hit;
	ecsm_pkg::pc_t        pc_next;

	// resolve subroutine operand names to physical registers
	function automatic ecsm_pkg::raddr_t map_addr(input ecsm_pkg::raddr_t a,
			input ecsm_pkg::mode_t m, input logic sw);
		ecsm_pkg::raddr_t r;
		unique case (a)
			ecsm_pkg::V_UX:   r = (m == ecsm_pkg::MODE_ACC) ? ecsm_pkg::R_AX : ecsm_pkg::R_PX;
			ecsm_pkg::V_UY:   r = (m == ecsm_pkg::MODE_ACC) ? ecsm_pkg::R_AY : ecsm_pkg::R_PY;
			ecsm_pkg::V_VX:   r = (m == ecsm_pkg::MODE_PQ) ? ecsm_pkg::R_QX : ecsm_pkg::R_PX;
			ecsm_pkg::V_VY:   r = (m == ecsm_pkg::MODE_PQ) ? ecsm_pkg::R_QY : ecsm_pkg::R_PY;
			ecsm_pkg::V_DX:   r = (m == ecsm_pkg::MODE_DBL) ? ecsm_pkg::R_PX : ecsm_pkg::R_AX;
			ecsm_pkg::V_DY:   r = (m == ecsm_pkg::MODE_DBL) ? ecsm_pkg::R_PY : ecsm_pkg::R_AY;
			ecsm_pkg::V_ROLD: r = sw ? ecsm_pkg::R_RB : ecsm_pkg::R_RA;
			ecsm_pkg::V_RNEW: r = sw ? ecsm_pkg::R_RA : ecsm_pkg::R_RB;
			ecsm_pkg::V_TOLD: r = sw ? ecsm_pkg::R_TB : ecsm_pkg::R_TA;
			ecsm_pkg::V_TNEW: r = sw ? ecsm_pkg::R_TA : ecsm_pkg::R_TB;
			default:          r = a;
		endcase
		return r;
	endfunction

	assign ui      = ecsm_pkg::ucode(pc_q);
	assign pc_next = ecsm_pkg::pc_t'(pc_q + 1'b1);
	assign busy    = (state_q != S_IDLE);
	assign cmd     = cmd_q;

	always_comb begin
		unique case (ui.cond)
			ecsm_pkg::C_ALWAYS: hit = 1'b1;
			ecsm_pkg::C_FLAG:   hit = status.flag;
			ecsm_pkg::C_NFLAG:  hit = !status.flag;
			ecsm_pkg::C_KZERO:  hit = status.k_zero;
			ecsm_pkg::C_KLSB0:  hit = !status.k_lsb;
			ecsm_pkg::C_PSMALL: hit = status.p_small;
			ecsm_pkg::C_CMDADD: hit = status.cmd_add;
			default:            hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			ret_q   <= '0;
			mode_q  <= ecsm_pkg::MODE_PQ;
			swap_q  <= 1'b0;
			cmd_q   <= '0;
		end else begin
			cmd_q.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						pc_q    <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					unique case (ui.kind)
						ecsm_pkg::UK_OP: begin
							cmd_q.valid <= 1'b1;
							cmd_q.op    <= ui.op;
							cmd_q.dst   <= map_addr(ui.dst, mode_q, swap_q);
							cmd_q.sa    <= map_addr(ui.sa, mode_q, swap_q);
							cmd_q.sb    <= map_addr(ui.sb, mode_q, swap_q);
							cmd_q.msel  <= ui.msel;
							state_q     <= S_WAIT;
						end
						ecsm_pkg::UK_BR: pc_q <= hit ? ui.target : pc_next;
						ecsm_pkg::UK_CALL: begin
							ret_q  <= pc_next;
							mode_q <= ui.mode;
							swap_q <= 1'b0;
							pc_q   <= ui.target;
						end
						ecsm_pkg::UK_RET: pc_q <= ret_q;
						ecsm_pkg::UK_SWAP: begin
							swap_q <= !swap_q;
							pc_q   <= pc_next;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_WAIT: begin
					if (status.done) begin
						pc_q    <= pc_next;
						state_q <= S_FETCH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ecsm_dp.sv =====
`timescale 1ns / 1ps

module ecsm_dp #(
	parameter int FW = 32,
	parameter int SW = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  ecsm_pkg::item_t                   item,
	input  logic                              cfg_we,
	input  logic [ecsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ecsm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  ecsm_pkg::dp_cmd_t                 cmd,
	output ecsm_pkg::dp_status_t              status,
	output logic                              done,
	output ecsm_pkg::result_t                 result
);

	localparam int CNT_W = $clog2(FW);
	localparam int CW    = ecsm_pkg::COORD_W;

	typedef enum logic [4:0] {
		D_IDLE = 5'b00001,
		D_EXEC = 5'b00010,
		D_ITER = 5'b00100,
		D_WB   = 5'b01000,
		D_WB2  = 5'b10000
	} dstate_t;

	dstate_t                 state_q;
	logic [FW-1:0]           mod_q;
	logic [FW-1:0]           ca_q;
	ecsm_pkg::item_t         item_q;
	logic [FW-1:0]           mem [ecsm_pkg::NUM_PHYS];
	logic [FW-1:0]           rd_a_q, rd_b_q;
	logic [FW-1:0]           sh_q, acc_q, dv_q, mb_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SW-1:0]           k_q;
	logic                    flag_q, done_q, rdone_q;
	ecsm_pkg::dp_op_t        op_q;
	ecsm_pkg::raddr_t        dst_q, sa_q;
	ecsm_pkg::msel_t         msel_q;
	ecsm_pkg::result_t       res_q;

	logic                    iter_op;
	logic [FW-1:0]           msrc;
	logic [FW:0]             add_s, add_r;
	logic [FW-1:0]           sub_r;
	logic [FW:0]             m1, m1r, m2, m2r;
	logic [FW:0]             d1, d1r;
	logic                    dge;
	logic                    we;
	ecsm_pkg::raddr_t        wa;
	logic [FW-1:0]           wd;

	assign iter_op = (op_q == ecsm_pkg::OP_MUL) || (op_q == ecsm_pkg::OP_DIV) ||
		(op_q == ecsm_pkg::OP_MOD);

	always_comb begin
		unique case (msel_q)
			ecsm_pkg::MS_PX: msrc = item_q.px[FW-1:0];
			ecsm_pkg::MS_PY: msrc = item_q.py[FW-1:0];
			ecsm_pkg::MS_QX: msrc = item_q.qx[FW-1:0];
			ecsm_pkg::MS_QY: msrc = item_q.qy[FW-1:0];
			default:         msrc = ca_q;
		endcase
	end

	// combinational modular add and subtract, operands below p
	always_comb begin
		add_s = {1'b0, rd_a_q} + {1'b0, rd_b_q};
		add_r = (add_s >= {1'b0, mod_q}) ? add_s - {1'b0, mod_q} : add_s;
		sub_r = (rd_a_q >= rd_b_q) ? rd_a_q - rd_b_q : rd_a_q - rd_b_q + mod_q;
	end

	// one multiplier bit per cycle, msb first: acc = 2*acc + bit*b mod p
	always_comb begin
		m1  = {acc_q, 1'b0};
		m1r = (m1 >= {1'b0, mod_q}) ? m1 - {1'b0, mod_q} : m1;
		m2  = {1'b0, m1r[FW-1:0]} + (sh_q[FW-1] ? {1'b0, mb_q} : '0);
		m2r = (m2 >= {1'b0, mod_q}) ? m2 - {1'b0, mod_q} : m2;
	end

	// restoring divide, one quotient bit per cycle
	always_comb begin
		d1  = {acc_q, sh_q[FW-1]};
		dge = (d1 >= {1'b0, dv_q});
		d1r = dge ? d1 - {1'b0, dv_q} : d1;
	end

	always_comb begin
		we = 1'b0;
		wa = dst_q;
		wd = rd_a_q;
		unique case (state_q)
			D_EXEC: begin
				unique case (op_q)
					ecsm_pkg::OP_MOV: we = 1'b1;
					ecsm_pkg::OP_ADD: begin
						we = 1'b1;
						wd = add_r[FW-1:0];
					end
					ecsm_pkg::OP_SUB: begin
						we = 1'b1;
						wd = sub_r;
					end
					ecsm_pkg::OP_LD0: begin
						we = 1'b1;
						wd = '0;
					end
					ecsm_pkg::OP_LD1: begin
						we = 1'b1;
						wd = FW'(1);
					end
					ecsm_pkg::OP_LDP: begin
						we = 1'b1;
						wd = mod_q;
					end
					default: we = 1'b0;
				endcase
			end
			D_WB: begin
				we = 1'b1;
				wd = (op_q == ecsm_pkg::OP_DIV) ? sh_q : acc_q;
			end
			D_WB2: begin
				we = 1'b1;
				wa = sa_q;
				wd = acc_q;
			end
			default: we = 1'b0;
		endcase
	end

	// register file: one write, two registered reads
	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (state_q == D_IDLE && cmd.valid) begin
			rd_a_q <= mem[cmd.sa];
			rd_b_q <= mem[cmd.sb];
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			item_q <= item;
		if (state_q == D_IDLE && cmd.valid) begin
			op_q   <= cmd.op;
			dst_q  <= cmd.dst;
			sa_q   <= cmd.sa;
			msel_q <= cmd.msel;
		end
		if (state_q == D_EXEC) begin
			acc_q <= '0;
			mb_q  <= rd_b_q;
			unique case (op_q)
				ecsm_pkg::OP_MOD: begin
					sh_q <= msrc;
					dv_q <= mod_q;
				end
				ecsm_pkg::OP_DIV: begin
					sh_q <= rd_a_q;
					dv_q <= rd_b_q;
				end
				default: begin
					sh_q <= rd_a_q;
					dv_q <= mod_q;
				end
			endcase
			if (op_q == ecsm_pkg::OP_OUT)
				res_q <= '{rx: CW'(rd_a_q), ry: CW'(rd_b_q)};
			if (op_q == ecsm_pkg::OP_KLD)
				k_q <= item_q.scalar[SW-1:0];
			if (op_q == ecsm_pkg::OP_KSH)
				k_q <= k_q >> 1;
		end
		if (state_q == D_ITER) begin
			if (op_q == ecsm_pkg::OP_MUL) begin
				acc_q <= m2r[FW-1:0];
				sh_q  <= sh_q << 1;
			end else begin
				acc_q <= d1r[FW-1:0];
				sh_q  <= {sh_q[FW-2:0], dge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			mod_q   <= FW'(ecsm_pkg::MODULUS_RESET);
			ca_q    <= FW'(ecsm_pkg::CURVE_A_RESET);
			cnt_q   <= '0;
			flag_q  <= 1'b0;
			done_q  <= 1'b0;
			rdone_q <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			rdone_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					ecsm_pkg::CFG_MODULUS: mod_q <= cfg_data[FW-1:0];
					ecsm_pkg::CFG_CURVE_A: ca_q  <= cfg_data[FW-1:0];
				endcase
			end
			unique case (state_q)
				D_IDLE: begin
					if (cmd.valid)
						state_q <= D_EXEC;
				end
				D_EXEC: begin
					if (iter_op) begin
						cnt_q   <= '0;
						state_q <= D_ITER;
					end else begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
						if (op_q == ecsm_pkg::OP_TST)
							flag_q <= (rd_a_q == '0) && (rd_b_q == '0);
						if (op_q == ecsm_pkg::OP_EQ)
							flag_q <= (rd_a_q == rd_b_q);
						if (op_q == ecsm_pkg::OP_OUT)
							rdone_q <= 1'b1;
					end
				end
				D_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(FW - 1))
						state_q <= D_WB;
				end
				D_WB: begin
					if (op_q == ecsm_pkg::OP_DIV) begin
						state_q <= D_WB2;
					end else begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				D_WB2: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign status = '{
		done:    done_q,
		flag:    flag_q,
		k_zero:  (k_q == '0),
		k_lsb:   k_q[0],
		p_small: (mod_q < FW'(2)),
		cmd_add: (item_q.cmd == ecsm_pkg::CMD_ADD)
	};
	assign done   = rdone_q;
	assign result = res_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == D_EXEC && op_q == ecsm_pkg::OP_DIV) |-> (rd_b_q != '0))
		else $error("divide issued with zero divisor");

	a_cmd_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> (state_q == D_IDLE))
		else $error("command while datapath busy");

	a_result_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		rdone_q |-> done_q)
		else $error("result strobe without op completion");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("op completion held longer than one cycle");

endmodule

// ===== hw/rtl/ec_point_scalar_multiply.sv =====
// Elliptic-curve point unit, affine coordinates over GF(p). Raise start for one
// cycle while busy is low to hand in one item: cmd 0 multiplies P by scalar
// (right-to-left double-and-add), cmd 1 adds P and Q; (0,0) is the point at
// infinity both ways. Exactly one result comes back per item on result, valid
// for the single cycle in which done is high; there is no way to hold it, so
// the receiver must take it then. modulus and curve_a are written through
// cfg_we/cfg_index/cfg_data and must only change while busy is low. All field
// work runs one micro-op at a time on a bit-serial unit that does one bit of a
// modular multiply or divide per cycle. A point operation is dominated by the
// extended-Euclid inverse, and a scalar multiply item runs up to about
// 2*SCALAR_WIDTH point operations.
`timescale 1ns / 1ps

module ec_point_scalar_multiply #(
	parameter int FIELD_WIDTH  = 32,
	parameter int SCALAR_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  ecsm_pkg::item_t                   item,
	output logic                              done,
	output ecsm_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [ecsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ecsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// command beat toward the datapath and its status back
	ecsm_pkg::dp_cmd_t    dp_cmd;
	ecsm_pkg::dp_status_t dp_status;
	logic                 accept;

	// an item is taken only when the sequencer is idle
	assign accept = start && !busy;

	// micro-program sequencer: double-and-add loop, point add subroutine,
	// euclid loop with operand swapping
	ecsm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.busy   (busy),
		.cmd    (dp_cmd),
		.status (dp_status)
	);

	// register file, bit-serial mul/div unit, config registers, result register
	ecsm_dp #(
		.FW (FIELD_WIDTH),
		.SW (SCALAR_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	typedef struct {
		bit [63:0] x;
		bit [63:0] y;
	} ec_point_t;

	// keeps its own copy of modulus and curve_a and a queue of expected result points
	class ec_scoreboard;
		bit [63:0]         modulus;
		bit [63:0]         curve_a;
		ecsm_pkg::result_t want_q[$];
		int                errors;

		function new();
			modulus = ecsm_pkg::MODULUS_RESET;
			curve_a = ecsm_pkg::CURVE_A_RESET;
			errors = 0;
		endfunction

		function void set_reg(logic [ecsm_pkg::CFG_IDX_W-1:0] idx,
				logic [ecsm_pkg::CFG_DATA_W-1:0] v);
			if (idx == ecsm_pkg::CFG_MODULUS) begin
				modulus = v;
			end else begin
				curve_a = v;
			end
		endfunction

		function bit [63:0] fsub(bit [63:0] u, bit [63:0] v, bit [63:0] p);
			return (u + p - v) % p;
		endfunction

		function bit [63:0] fmul(bit [63:0] u, bit [63:0] v, bit [63:0] p);
			return (u * v) % p;
		endfunction

		// extended euclid, 0 when d has no inverse
		function bit invert(bit [63:0] d, bit [63:0] p, output bit [63:0] inv);
			bit [63:0] r0, r1, r2, t0, t1, t2, q;
			r0 = p;
			r1 = d % p;
			t0 = 0;
			t1 = 1 % p;
			inv = 0;
			while (r1 != 0) begin
				q = r0 / r1;
				r2 = r0 - q * r1;
				t2 = fsub(t0, fmul(q % p, t1, p), p);
				r0 = r1;
				r1 = r2;
				t0 = t1;
				t1 = t2;
			end
			if (r0 != 1)
				return 0;
			inv = t0;
			return 1;
		endfunction

		function ec_point_t point_add(ec_point_t u, ec_point_t v, bit [63:0] p, bit [63:0] a);
			ec_point_t r;
			bit [63:0] num, den, inv, lam;
			r.x = 0;
			r.y = 0;
			if (u.x == 0 && u.y == 0)
				return v;
			if (v.x == 0 && v.y == 0)
				return u;
			if (u.x == v.x && u.y == v.y) begin
				num = (fmul(fmul(u.x, u.x, p), 3 % p, p) + a) % p;
				den = fmul(u.y, 2 % p, p);
			end else begin
				num = fsub(v.y, u.y, p);
				den = fsub(v.x, u.x, p);
			end
			if (den == 0 || !invert(den, p, inv))
				return r;
			lam = fmul(num, inv, p);
			r.x = fsub(fsub(fmul(lam, lam, p), u.x, p), v.x, p);
			r.y = fsub(fmul(lam, fsub(u.x, r.x, p), p), u.y, p);
			return r;
		endfunction

		// right-to-left double-and-add
		function ec_point_t point_mul(ec_point_t base, bit [63:0] k, bit [63:0] p, bit [63:0] a);
			ec_point_t acc, cur;
			acc.x = 0;
			acc.y = 0;
			cur = base;
			while (k != 0) begin
				if (k[0])
					acc = point_add(acc, cur, p, a);
				cur = point_add(cur, cur, p, a);
				k >>= 1;
			end
			return acc;
		endfunction

		function void note_beat(ecsm_pkg::item_t it);
			ec_point_t pp, qq, rr;
			bit [63:0] p, a;
			ecsm_pkg::result_t want;
			p = modulus;
			rr.x = 0;
			rr.y = 0;
			if (p >= 2) begin
				a = curve_a % p;
				pp.x = it.px % p;
				pp.y = it.py % p;
				qq.x = it.qx % p;
				qq.y = it.qy % p;
				if (it.cmd == ecsm_pkg::CMD_MUL)
					rr = point_mul(pp, it.scalar, p, a);
				else
					rr = point_add(pp, qq, p, a);
			end
			want.rx = rr.x[ecsm_pkg::COORD_W-1:0];
			want.ry = rr.y[ecsm_pkg::COORD_W-1:0];
			want_q = {want_q, want};
		endfunction

		function void check_beat(ecsm_pkg::result_t got);
			ecsm_pkg::result_t want;
			if (want_q.size() == 0) begin
				$error("result beat with nothing expected: rx %0d ry %0d", got.rx, got.ry);
				errors++;
				return;
			end
			want = want_q.pop_front();
			if (got.rx !== want.rx) begin
				$error("rx mismatch: expected %0d, got %0d", want.rx, got.rx);
				errors++;
			end
			if (got.ry !== want.ry) begin
				$error("ry mismatch: expected %0d, got %0d", want.ry, got.ry);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	ecsm_pkg::item_t                 item;
	logic                            done;
	ecsm_pkg::result_t               result;
	logic                            cfg_we;
	logic [ecsm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ecsm_pkg::CFG_DATA_W-1:0] cfg_data;

	ec_scoreboard sb = new();
	int idle_pct;

	ec_point_scalar_multiply dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// result beats last one cycle and cannot be held off, so check every strobe
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_beat(result);
	end

	// both registers in one go so cfg_we is never dropped and raised in one step
	task automatic write_regs(bit [31:0] m, bit [31:0] a);
		cfg_we <= 1'b1;
		cfg_index <= ecsm_pkg::CFG_MODULUS;
		cfg_data <= m;
		@(posedge clk);
		sb.set_reg(ecsm_pkg::CFG_MODULUS, m);
		cfg_index <= ecsm_pkg::CFG_CURVE_A;
		cfg_data <= a;
		@(posedge clk);
		sb.set_reg(ecsm_pkg::CFG_CURVE_A, a);
		cfg_we <= 1'b0;
	endtask

	// hold start with the beat until busy is seen low ahead of an edge
	task automatic send_beat(ecsm_pkg::item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sb.note_beat(it);
	endtask

	// wait for every expected result, then a short settle before touching config
	task automatic drain();
		start <= 1'b0;
		while (sb.want_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic ecsm_pkg::item_t mk(logic c, logic [31:0] px, logic [31:0] py,
			logic [31:0] qx, logic [31:0] qy, logic [63:0] k);
		ecsm_pkg::item_t it;
		it.cmd = c;
		it.px = px;
		it.py = py;
		it.qx = qx;
		it.qy = qy;
		it.scalar = k;
		return it;
	endfunction

	// random beat: adds often pair P with itself or its negation, scalars mostly short
	function automatic ecsm_pkg::item_t rand_beat();
		ecsm_pkg::item_t it;
		bit [63:0] p, ny;
		int pick;
		p = sb.modulus;
		it.cmd = $urandom_range(1) ? ecsm_pkg::CMD_ADD : ecsm_pkg::CMD_MUL;
		it.px = $urandom_range(32'hFFFF_FFFE, 0);
		it.py = $urandom_range(32'hFFFF_FFFE, 0);
		if ($urandom_range(3) == 0 && p >= 2) begin
			it.px = it.px % p;
			it.py = it.py % p;
		end
		it.qx = $urandom_range(32'hFFFF_FFFE, 0);
		it.qy = $urandom_range(32'hFFFF_FFFE, 0);
		pick = $urandom_range(3);
		if (pick == 0) begin
			it.qx = it.px;
			it.qy = it.py;
		end else if (pick == 1 && p >= 2) begin
			ny = (p - (it.py % p)) % p;
			it.qx = it.px;
			it.qy = ny[31:0];
		end
		if ($urandom_range(19) == 0)
			it.scalar = {$urandom, $urandom};
		else
			it.scalar = $urandom_range(63, 0);
		if ($urandom_range(15) == 0)
			it.scalar = 64'd0;
		return it;
	endfunction

	initial begin
		bit [31:0] mods[6];
		bit [31:0] as[6];
		bit [63:0] p;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = ecsm_pkg::CFG_MODULUS;
		cfg_data = '0;
		idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset config first
		p = ecsm_pkg::MODULUS_RESET;
		send_beat(mk(ecsm_pkg::CMD_MUL, 32'd5, 32'd7, 32'd0, 32'd0, 64'd0));
		send_beat(mk(ecsm_pkg::CMD_MUL, 32'd5, 32'd7, 32'd0, 32'd0, 64'd1));
		send_beat(mk(ecsm_pkg::CMD_MUL, 32'd0, 32'd0, 32'd0, 32'd0, 64'd9));
		send_beat(mk(ecsm_pkg::CMD_MUL, 32'd12, 32'd0, 32'd0, 32'd0, 64'd2));
		send_beat(mk(ecsm_pkg::CMD_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'd0, 32'd0,
			64'hFFFF_FFFF_FFFF_FFFF));
		send_beat(mk(ecsm_pkg::CMD_MUL, p[31:0], p[31:0], 32'd0, 32'd0, 64'd3));
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'd0, 32'd0, 32'd3, 32'd4, 64'd0));
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'd3, 32'd4, 32'd0, 32'd0, 64'd0));
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'd3, 32'd4, 32'd3, p[31:0] - 32'd4, 64'd0));
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'd3, 32'd4, 32'd3, 32'd4, 64'd0));
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'd8, 32'd0, 32'd8, 32'd0, 64'd0));
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'd3, 32'd4, 32'd9, 32'd11,
			64'hFFFF_FFFF_FFFF_FFFF));
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'hFFFF_FFFE, 32'd1, 32'd2, 32'hFFFF_FFFE, 64'd0));
		drain();

		// modulus below two gives infinity for everything
		write_regs(32'd0, 32'd0);
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'd3, 32'd4, 32'd5, 32'd6, 64'd0));
		send_beat(mk(ecsm_pkg::CMD_MUL, 32'd3, 32'd4, 32'd0, 32'd0, 64'd5));
		drain();
		// composite modulus so some denominators have no inverse
		write_regs(32'd15, 32'hFFFF_FFFE);
		send_beat(mk(ecsm_pkg::CMD_ADD, 32'd1, 32'd2, 32'd4, 32'd7, 64'd0));
		send_beat(mk(ecsm_pkg::CMD_MUL, 32'd1, 32'd2, 32'd0, 32'd0, 64'd6));
		drain();

		mods = '{32'd1000000007, 32'd97, 32'd4294967291, 32'd4294967295, 32'd2, 32'd65521};
		as = '{32'd0, 32'd2, 32'd4294967294, 32'd5, 32'd1, 32'd3};
		for (int ph = 0; ph < 6; ph++) begin
			write_regs(mods[ph], as[ph]);
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 83;
				2: idle_pct = 0;
				default: idle_pct = 36;
			endcase
			for (int n = 0; n < 17; n++)
				send_beat(rand_beat());
			drain();
		end

		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#1_000_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
